>>> hw/rtl/mrpt_pkg.sv
// Package for the Miller-Rabin prime test unit: widths, limits, base table
// and the sequencer state type. No dependencies.
package mrpt_pkg;

  localparam int unsigned NUM_W = 33;
  localparam int unsigned CNT_W = 6;

  localparam logic [NUM_W-1:0] MR_LIMIT = 33'd4759123141;

  localparam logic [1:0] BASE_LAST = 2'd2;

  typedef logic [NUM_W-1:0] num_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SPLIT,
    S_BREDUCE,
    S_POW_STEP,
    S_PMUL,
    S_PSQR,
    S_CHECK,
    S_WSQR
  } mrpt_state_e;

  // Witness bases in test order.
  function automatic logic [5:0] mr_base(input logic [1:0] idx);
    logic [5:0] base;
    case (idx)
      2'd0:    base = 6'd2;
      2'd1:    base = 6'd7;
      2'd2:    base = 6'd61;
      default: base = 6'd2;
    endcase
    return base;
  endfunction

endpackage

>>> hw/rtl/mrpt_mulmod.sv
// Bit-serial modular multiplier for the Miller-Rabin prime test unit.
// Depends on mrpt_pkg for widths.
module mrpt_mulmod (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  mrpt_pkg::num_t a_i,
  input  mrpt_pkg::num_t b_i,
  input  mrpt_pkg::num_t n_i,
  output mrpt_pkg::num_t prod_o,
  output logic           done_o
);
  import mrpt_pkg::*;

  logic busy_q, busy_d;
  logic done_q, done_d;
  cnt_t cnt_q, cnt_d;
  num_t acc_q, acc_d;
  num_t a_q, a_d;
  num_t b_q, b_d;
  num_t n_q, n_d;

  logic [NUM_W:0] dbl, dbl_red, sum, sum_red;

  // One bit of b per cycle, most significant first; acc stays below n.
  always_comb begin
    dbl     = {acc_q, 1'b0};
    dbl_red = (dbl >= {1'b0, n_q}) ? dbl - {1'b0, n_q} : dbl;
    sum     = b_q[NUM_W-1] ? dbl_red + {1'b0, a_q} : dbl_red;
    sum_red = (sum >= {1'b0, n_q}) ? sum - {1'b0, n_q} : sum;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    n_d    = n_q;
    if (busy_q) begin
      acc_d = sum_red[NUM_W-1:0];
      b_d   = {b_q[NUM_W-2:0], 1'b0};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (start_i) begin
      busy_d = 1'b1;
      acc_d  = '0;
      a_d    = a_i;
      b_d    = b_i;
      n_d    = n_i;
      cnt_d  = CNT_W'(NUM_W - 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
    n_q   <= n_d;
  end

  assign prod_o = acc_q;
  assign done_o = done_q;

endmodule

>>> hw/rtl/miller_rabin_prime_test_unit.sv
// Top level of the deterministic Miller-Rabin prime test (bases 2, 7, 61).
// Depends on mrpt_pkg and instantiates mrpt_mulmod.
//
//  Channel  | Ports                                 | Handshake
//  ---------+---------------------------------------+-----------------------------
//  command  | start, busy, number_i                 | word taken when start && !busy
//  result   | result_valid_o, is_prime_o,           | word shown for one cycle,
//           | out_of_range_o                        | no backpressure
//
// Trivial cases (out of range, below 2, 2, 3, even, 7, 61) answer in the cycle
// after the command word. Every other number first strips trailing zeros of
// n-1 (r zero bits), then runs three bases on one shared bit-serial modular
// multiplier. With k bits in the odd part d (k + r <= 33), a base costs one
// reduction, up to k products and k-1 squarings for the power, one check and
// up to r-1 squarings. busy stays high while a full test runs.
// Reset is asynchronous and active low; it returns the sequencer to idle.
// The receiver cannot stall: the result strobe lasts exactly one cycle.
module miller_rabin_prime_test_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  mrpt_pkg::num_t number_i,
  output logic           result_valid_o,
  output logic           is_prime_o,
  output logic           out_of_range_o
);
  import mrpt_pkg::*;

  mrpt_state_e state_q, state_d;
  logic        issued_q, issued_d;
  logic        valid_q, valid_d;
  logic        prime_q, prime_d;
  logic        oor_q, oor_d;
  logic [1:0]  base_q, base_d;
  cnt_t        r_q, r_d;
  cnt_t        j_q, j_d;
  num_t        n_q, n_d;
  num_t        d_q, d_d;
  num_t        e_q, e_d;
  num_t        res_q, res_d;
  num_t        bb_q, bb_d;

  num_t nm1;
  logic mul_start, mul_done;
  num_t mul_a, mul_b, mul_prod;

  assign nm1 = n_q - 33'd1;

  // The shared multiplier's operands follow the sequencer step.
  always_comb begin
    case (state_q)
      S_BREDUCE: begin
        mul_a = 33'd1;
        mul_b = {27'd0, mr_base(base_q)};
      end
      S_PMUL: begin
        mul_a = res_q;
        mul_b = bb_q;
      end
      S_PSQR: begin
        mul_a = bb_q;
        mul_b = bb_q;
      end
      default: begin
        mul_a = res_q;
        mul_b = res_q;
      end
    endcase
  end

  mrpt_mulmod u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .n_i     (n_q),
    .prod_o  (mul_prod),
    .done_o  (mul_done)
  );

  always_comb begin
    state_d   = state_q;
    issued_d  = issued_q;
    valid_d   = 1'b0;
    prime_d   = prime_q;
    oor_d     = oor_q;
    base_d    = base_q;
    r_d       = r_q;
    j_d       = j_q;
    n_d       = n_q;
    d_d       = d_q;
    e_d       = e_q;
    res_d     = res_q;
    bb_d      = bb_q;
    mul_start = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          n_d   = number_i;
          oor_d = 1'b0;
          if (number_i >= MR_LIMIT) begin
            valid_d = 1'b1;
            prime_d = 1'b0;
            oor_d   = 1'b1;
          end else if (number_i < 33'd2) begin
            valid_d = 1'b1;
            prime_d = 1'b0;
          end else if (number_i == 33'd2 || number_i == 33'd3) begin
            valid_d = 1'b1;
            prime_d = 1'b1;
          end else if (!number_i[0]) begin
            valid_d = 1'b1;
            prime_d = 1'b0;
          end else if (number_i == 33'd7 || number_i == 33'd61) begin
            valid_d = 1'b1;
            prime_d = 1'b1;
          end else begin
            d_d     = number_i - 33'd1;
            r_d     = '0;
            state_d = S_SPLIT;
          end
        end
      end

      // Write n-1 as d * 2^r with d odd.
      S_SPLIT: begin
        if (!d_q[0]) begin
          d_d = {1'b0, d_q[NUM_W-1:1]};
          r_d = r_q + CNT_W'(1);
        end else begin
          base_d  = '0;
          state_d = S_BREDUCE;
        end
      end

      // Reduce the base modulo n as the product 1 * base.
      S_BREDUCE: begin
        if (!issued_q) begin
          mul_start = 1'b1;
          issued_d  = 1'b1;
        end else if (mul_done) begin
          issued_d = 1'b0;
          bb_d     = mul_prod;
          res_d    = 33'd1;
          e_d      = d_q;
          state_d  = S_POW_STEP;
        end
      end

      // Square-and-multiply from the low exponent bit.
      S_POW_STEP: begin
        if (e_q == '0) begin
          state_d = S_CHECK;
        end else if (e_q[0]) begin
          state_d = S_PMUL;
        end else begin
          state_d = S_PSQR;
        end
      end

      S_PMUL: begin
        if (!issued_q) begin
          mul_start = 1'b1;
          issued_d  = 1'b1;
        end else if (mul_done) begin
          issued_d = 1'b0;
          res_d    = mul_prod;
          if (e_q[NUM_W-1:1] == '0) begin
            state_d = S_CHECK;
          end else begin
            state_d = S_PSQR;
          end
        end
      end

      S_PSQR: begin
        if (!issued_q) begin
          mul_start = 1'b1;
          issued_d  = 1'b1;
        end else if (mul_done) begin
          issued_d = 1'b0;
          bb_d     = mul_prod;
          e_d      = {1'b0, e_q[NUM_W-1:1]};
          state_d  = S_POW_STEP;
        end
      end

      // First look at a^d: 1 or n-1 passes this base at once.
      S_CHECK: begin
        if (res_q == 33'd1 || res_q == nm1) begin
          if (base_q == BASE_LAST) begin
            valid_d = 1'b1;
            prime_d = 1'b1;
            state_d = S_IDLE;
          end else begin
            base_d  = base_q + 2'd1;
            state_d = S_BREDUCE;
          end
        end else if (r_q > CNT_W'(1)) begin
          j_d     = CNT_W'(1);
          state_d = S_WSQR;
        end else begin
          valid_d = 1'b1;
          prime_d = 1'b0;
          state_d = S_IDLE;
        end
      end

      // Repeated squaring looking for n-1.
      S_WSQR: begin
        if (!issued_q) begin
          mul_start = 1'b1;
          issued_d  = 1'b1;
        end else if (mul_done) begin
          issued_d = 1'b0;
          res_d    = mul_prod;
          if (mul_prod == nm1) begin
            if (base_q == BASE_LAST) begin
              valid_d = 1'b1;
              prime_d = 1'b1;
              state_d = S_IDLE;
            end else begin
              base_d  = base_q + 2'd1;
              state_d = S_BREDUCE;
            end
          end else if ((j_q + CNT_W'(1)) < r_q) begin
            j_d = j_q + CNT_W'(1);
          end else begin
            valid_d = 1'b1;
            prime_d = 1'b0;
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d  = S_IDLE;
        issued_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      issued_q <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prime_q <= prime_d;
    oor_q   <= oor_d;
    base_q  <= base_d;
    r_q     <= r_d;
    j_q     <= j_d;
    n_q     <= n_d;
    d_q     <= d_d;
    e_q     <= e_d;
    res_q   <= res_d;
    bb_q    <= bb_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = valid_q;
  assign is_prime_o     = prime_q;
  assign out_of_range_o = oor_q;

endmodule
